>>> hw/rtl/flash_command_state_machine_macros.svh
// Assertion macros for the flash command state machine.
// No dependencies; included by the top level.
`ifndef FLASH_COMMAND_STATE_MACHINE_MACROS_SVH
`define FLASH_COMMAND_STATE_MACHINE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define FCSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcsm: same-cycle check failed");

// next-cycle implication, disabled in reset
`define FCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcsm: next-cycle check failed");

`else

`define FCSM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/fcsm_pkg.sv
// Shared types and command constants for the flash command state machine.
// No dependencies.
package fcsm_pkg;

    // widest supported array index
    localparam int MAX_ADDR_W = 24;
    localparam int INDEX_W    = 21;
    localparam int DATA_W     = 8;

    // command addresses and bytes
    localparam logic [15:0] CMD_ADDR_A = 16'h5555;
    localparam logic [15:0] CMD_ADDR_B = 16'h2aaa;
    localparam logic [7:0]  CMD_UNLOCK_A  = 8'haa;
    localparam logic [7:0]  CMD_UNLOCK_B  = 8'h55;
    localparam logic [7:0]  CMD_AUTOSEL   = 8'h90;
    localparam logic [7:0]  CMD_PROGRAM   = 8'ha0;
    localparam logic [7:0]  CMD_ERASE     = 8'h80;
    localparam logic [7:0]  CMD_CHIP_ERASE   = 8'h10;
    localparam logic [7:0]  CMD_SECTOR_ERASE = 8'h30;

    // read-back codes
    localparam logic [7:0] ID_MANUF   = 8'h01;
    localparam logic [7:0] ID_DEVICE  = 8'had;
    localparam logic [7:0] ID_NONE    = 8'h00;
    localparam logic [7:0] ERASE_DONE = 8'h80;
    localparam logic [7:0] ERASED     = 8'hff;

    typedef enum logic [3:0] {
        MODE_ARRAY        = 4'd0,
        MODE_UNLOCK1      = 4'd1,
        MODE_UNLOCK2      = 4'd2,
        MODE_IDENT        = 4'd3,
        MODE_BYTE_PGM     = 4'd4,
        MODE_ERASE1       = 4'd5,
        MODE_ERASE2       = 4'd6,
        MODE_ERASE3       = 4'd7,
        MODE_STATUS_LAST  = 4'd8,
        MODE_STATUS_FIRST = 4'd9
    } mode_t;

endpackage

>>> hw/rtl/flash_command_state_machine.sv
// Top level of the byte-wide parallel flash command state machine.
// Depends on fcsm_pkg.sv and flash_command_state_machine_macros.svh.
//
//  channel  | dir | signals                          | payload
//  ---------+-----+----------------------------------+--------------------------------
//  s_*      | in  | s_tvalid s_tready s_tdata s_tuser| access: index, write byte, kind
//  m_*      | out | m_tvalid m_tready m_tdata        | read byte (one item per read)
//
// A write item acts when it is accepted; a read item passes a registered memory read,
// then the output register. The next item is taken while a result waits in m_tdata.
// Erase commands run the shared address counter over the array one byte a cycle, over
// 2**min(SECTOR_BITS, ADDR_BITS) bytes for a sector or 2**ADDR_BITS for the chip;
// s_tready is low meanwhile.
// After reset the same counter clears the array to FF, with s_tready low.
// A stalled read result holds s_tready low only once a second read is pending.
`include "flash_command_state_machine_macros.svh"

module flash_command_state_machine
    import fcsm_pkg::*;
#(
    parameter int ADDR_BITS   = 21,
    parameter int SECTOR_BITS = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [20:0] byte_index, [28:21] write_data, [31:29] zero
    input  logic        s_tuser,   // [0] func: 0 read, 1 write
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] read_data
);

    localparam int DEPTH = 1 << ADDR_BITS;
    localparam int SEC_W = (SECTOR_BITS < ADDR_BITS) ? SECTOR_BITS : ADDR_BITS;
    localparam logic [ADDR_BITS-1:0] ALL_ONES = {ADDR_BITS{1'b1}};
    localparam logic [ADDR_BITS-1:0] SEC_MASK = ALL_ONES >> (ADDR_BITS - SEC_W);
    localparam logic [ADDR_BITS-1:0] ADDR_A   = ADDR_BITS'(CMD_ADDR_A);
    localparam logic [ADDR_BITS-1:0] ADDR_B   = ADDR_BITS'(CMD_ADDR_B);
    localparam logic [ADDR_BITS-1:0] ADDR_ID1 = ADDR_BITS'(1);

    typedef enum logic [1:0] {
        ST_SWEEP,   // clearing / erasing, one byte a cycle
        ST_IDLE,    // ready for an item
        ST_READ     // read data waits for the output register
    } state_t;

    state_t                 state_reg;
    mode_t                  mode_reg;
    logic [ADDR_BITS-1:0]   sweep_addr_reg;
    logic [ADDR_BITS-1:0]   sweep_last_reg;
    logic                   use_mem_reg;
    logic [DATA_W-1:0]      imm_reg;
    logic                   out_valid_reg;
    logic [DATA_W-1:0]      out_data_reg;
    logic [DATA_W-1:0]      mem_q_reg;

    logic [DATA_W-1:0]      mem [DEPTH];

    // decoded item fields
    logic [MAX_ADDR_W-1:0]  idx_ext;
    logic [ADDR_BITS-1:0]   a;
    logic [DATA_W-1:0]      d;
    logic                   is_write;
    logic                   accept;

    // command decode
    mode_t                  mode_next;
    logic                   erase_go;
    logic [ADDR_BITS-1:0]   erase_base;
    logic [ADDR_BITS-1:0]   erase_last;
    logic                   prog_we;
    logic                   rd_use_mem;
    logic [DATA_W-1:0]      rd_imm;

    // memory port
    logic                   sweeping;
    logic                   mem_we;
    logic [ADDR_BITS-1:0]   mem_wa;
    logic [DATA_W-1:0]      mem_wd;
    logic                   mem_re;

    assign idx_ext  = {{(MAX_ADDR_W - INDEX_W){1'b0}}, s_tdata[INDEX_W-1:0]};
    assign a        = idx_ext[ADDR_BITS-1:0];
    assign d        = s_tdata[INDEX_W +: DATA_W];
    assign is_write = s_tuser;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // command sequencer: next mode and side effects of one item
    always_comb
    begin
        mode_next  = mode_reg;
        erase_go   = 1'b0;
        erase_base = '0;
        erase_last = ALL_ONES;
        prog_we    = 1'b0;
        rd_use_mem = 1'b1;
        rd_imm     = ID_NONE;
        if (is_write)
        begin
            unique case (mode_reg)
                MODE_UNLOCK1:
                    mode_next = (a == ADDR_B && d == CMD_UNLOCK_B) ? MODE_UNLOCK2 : MODE_ARRAY;
                MODE_UNLOCK2:
                begin
                    if (a != ADDR_A)
                        mode_next = MODE_ARRAY;
                    else if (d == CMD_AUTOSEL)
                        mode_next = MODE_IDENT;
                    else if (d == CMD_PROGRAM)
                        mode_next = MODE_BYTE_PGM;
                    else if (d == CMD_ERASE)
                        mode_next = MODE_ERASE1;
                    else
                        mode_next = MODE_ARRAY;
                end
                MODE_ERASE1:
                    mode_next = (a == ADDR_A && d == CMD_UNLOCK_A) ? MODE_ERASE2 : MODE_ARRAY;
                MODE_ERASE2:
                    mode_next = (a == ADDR_B && d == CMD_UNLOCK_B) ? MODE_ERASE3 : MODE_ARRAY;
                MODE_ERASE3:
                begin
                    if (a == ADDR_A && d == CMD_CHIP_ERASE)
                    begin
                        erase_go  = 1'b1;
                        mode_next = MODE_STATUS_FIRST;
                    end
                    else if (d == CMD_SECTOR_ERASE)
                    begin
                        erase_go   = 1'b1;
                        erase_base = a & ~SEC_MASK;
                        erase_last = (a & ~SEC_MASK) | SEC_MASK;
                        mode_next  = MODE_STATUS_FIRST;
                    end
                    else
                        mode_next = MODE_ARRAY;
                end
                MODE_BYTE_PGM:
                begin
                    prog_we   = 1'b1;
                    mode_next = MODE_ARRAY;
                end
                default:
                    mode_next = (a == ADDR_A && d == CMD_UNLOCK_A) ? MODE_UNLOCK1 : MODE_ARRAY;
            endcase
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    rd_use_mem = 1'b0;
                    if (a == '0)
                        rd_imm = ID_MANUF;
                    else if (a == ADDR_ID1)
                        rd_imm = ID_DEVICE;
                    else
                        rd_imm = ID_NONE;
                end
                MODE_STATUS_FIRST:
                begin
                    rd_use_mem = 1'b0;
                    rd_imm     = ERASE_DONE;
                    mode_next  = MODE_STATUS_LAST;
                end
                MODE_STATUS_LAST:
                begin
                    rd_use_mem = 1'b0;
                    rd_imm     = ERASE_DONE;
                    mode_next  = MODE_ARRAY;
                end
                default:
                    rd_use_mem = 1'b1;
            endcase
        end
    end

    // one write port: the sweep counter or a program item
    assign sweeping = (state_reg == ST_SWEEP);
    assign mem_we   = sweeping || (accept && is_write && prog_we);
    assign mem_wa   = sweeping ? sweep_addr_reg : a;
    assign mem_wd   = sweeping ? ERASED : d;
    assign mem_re   = accept && !is_write;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            mem_q_reg <= mem[a];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            mode_reg       <= MODE_ARRAY;
            sweep_addr_reg <= '0;
            sweep_last_reg <= ALL_ONES;
            use_mem_reg    <= 1'b0;
            imm_reg        <= ID_NONE;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= ID_NONE;
        end
        else
        begin
            // the read wait state refills the output register itself
            if (out_valid_reg && m_tready && state_reg != ST_READ)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_SWEEP:
                begin
                    if (sweep_addr_reg == sweep_last_reg)
                        state_reg <= ST_IDLE;
                    else
                        sweep_addr_reg <= sweep_addr_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg <= mode_next;
                        if (!is_write)
                        begin
                            use_mem_reg <= rd_use_mem;
                            imm_reg     <= rd_imm;
                            state_reg   <= ST_READ;
                        end
                        else if (erase_go)
                        begin
                            sweep_addr_reg <= erase_base;
                            sweep_last_reg <= erase_last;
                            state_reg      <= ST_SWEEP;
                        end
                    end
                end
                ST_READ:
                begin
                    // move into the output register once it is free
                    if (!out_valid_reg || m_tready)
                    begin
                        out_data_reg  <= use_mem_reg ? mem_q_reg : imm_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // an accepted erase command starts the sweep with status pending
    `FCSM_ASSERT_NEXT(a_erase_starts, clk, rst_n, accept && is_write && erase_go, state_reg == ST_SWEEP && mode_reg == MODE_STATUS_FIRST)

    // a sweep keeps running until the counter meets its end address
    `FCSM_ASSERT_NEXT(a_sweep_holds, clk, rst_n, state_reg == ST_SWEEP && sweep_addr_reg != sweep_last_reg, state_reg == ST_SWEEP)

    // a new result only comes out of the read wait state
    `FCSM_ASSERT_IMPL(a_result_source, clk, rst_n, m_tvalid && !$past(m_tvalid), $past(state_reg == ST_READ))

endmodule

>>> tb/tb_flash_command_state_machine.sv
// Self-checking testbench for the flash command state machine: directed table, then random
// command sequences, each read checked against a table value or an in-bench model of the flash.
// Depends on fcsm_pkg.sv and the flash_command_state_machine RTL.
module tb_flash_command_state_machine;
    import fcsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_BITS    = 21;
    localparam int SECTOR_BITS  = 16;
    localparam int RANDOM_ITEMS = 1500;
    // erases and the post-reset clear hold s_tready low for up to one sweep over 2**ADDR_BITS bytes
    localparam int unsigned IDLE_LIMIT = 3 * (1 << ADDR_BITS);

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [20:0] IDX_MASK  = 21'((64'd1 << ADDR_BITS) - 1);
    localparam logic [20:0] CMD_A_IDX = 21'(CMD_ADDR_A);
    localparam logic [20:0] CMD_B_IDX = 21'(CMD_ADDR_B);
    localparam logic [20:0] TOP_IDX   = 21'h1fffff;

    // one directed access; want is used only when known is set
    typedef struct packed {
        logic        fw;
        logic [20:0] idx;
        logic [7:0]  wd;
        logic        known;
        logic [7:0]  want;
    } access_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [20:0] byte_index, [28:21] write_data, [31:29] zero
    logic        s_tuser  = 1'b0; // [0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] read_data

    // flash shadow: command mode plus the bytes programmed since their last erase
    mode_t       fl_mode = MODE_ARRAY;
    logic [7:0]  fl_bytes [int unsigned];

    logic [7:0]  read_expect [$];
    logic [20:0] hot_addrs [$];    // recently programmed indexes, for read-back
    int          n_sent = 0;
    int          errors = 0;
    int unsigned idle_cycles = 0;
    int          sector_erases_left = 7; // each sector erase sweeps 2**SECTOR_BITS bytes
    bit          chip_erase_ok = 1'b1;   // chip erase only in the directed part
    bit          src_burst = 1'b0;
    bit          snk_burst = 1'b0;

    // directed accesses
    access_row_t script [0:29] = '{
        '{FUNC_READ,  21'h000000, 8'h00,            1'b1, ERASED},     // fresh after clear
        '{FUNC_WRITE, CMD_A_IDX,  CMD_UNLOCK_A,     1'b0, 8'h00},
        '{FUNC_WRITE, CMD_B_IDX,  CMD_UNLOCK_B,     1'b0, 8'h00},
        '{FUNC_WRITE, CMD_A_IDX,  CMD_AUTOSEL,      1'b0, 8'h00},
        '{FUNC_READ,  21'h000000, 8'h00,            1'b1, ID_MANUF},
        '{FUNC_READ,  21'h000001, 8'hff,            1'b1, ID_DEVICE},  // write byte ignored
        '{FUNC_READ,  TOP_IDX,    8'h00,            1'b1, ID_NONE},
        '{FUNC_WRITE, CMD_A_IDX,  CMD_UNLOCK_A,     1'b0, 8'h00},      // leaves autoselect
        '{FUNC_READ,  TOP_IDX,    8'h00,            1'b0, 8'h00},      // read mid-unlock
        '{FUNC_WRITE, CMD_B_IDX,  CMD_UNLOCK_B,     1'b0, 8'h00},
        '{FUNC_WRITE, CMD_A_IDX,  CMD_PROGRAM,      1'b0, 8'h00},
        '{FUNC_WRITE, TOP_IDX,    8'h00,            1'b0, 8'h00},
        '{FUNC_READ,  TOP_IDX,    8'h00,            1'b1, 8'h00},
        '{FUNC_WRITE, CMD_A_IDX,  CMD_UNLOCK_A,     1'b0, 8'h00},
        '{FUNC_WRITE, CMD_B_IDX,  CMD_UNLOCK_B,     1'b0, 8'h00},
        '{FUNC_WRITE, CMD_A_IDX,  CMD_ERASE,        1'b0, 8'h00},
        '{FUNC_WRITE, CMD_A_IDX,  CMD_UNLOCK_A,     1'b0, 8'h00},
        '{FUNC_WRITE, CMD_B_IDX,  CMD_UNLOCK_B,     1'b0, 8'h00},
        '{FUNC_WRITE, 21'h1f0000, CMD_SECTOR_ERASE, 1'b0, 8'h00},      // top sector
        '{FUNC_READ,  21'h000000, 8'h00,            1'b1, ERASE_DONE},
        '{FUNC_WRITE, 21'h1f0001, 8'hff,            1'b0, 8'h00},      // write ends status
        '{FUNC_READ,  TOP_IDX,    8'h00,            1'b1, ERASED},
        '{FUNC_WRITE, CMD_A_IDX,  CMD_UNLOCK_A,     1'b0, 8'h00},
        '{FUNC_WRITE, CMD_B_IDX,  CMD_UNLOCK_B,     1'b0, 8'h00},
        '{FUNC_WRITE, CMD_A_IDX,  CMD_ERASE,        1'b0, 8'h00},
        '{FUNC_WRITE, CMD_A_IDX,  CMD_UNLOCK_A,     1'b0, 8'h00},
        '{FUNC_WRITE, CMD_B_IDX,  CMD_UNLOCK_B,     1'b0, 8'h00},
        '{FUNC_WRITE, CMD_A_IDX,  CMD_CHIP_ERASE,   1'b0, 8'h00},
        '{FUNC_READ,  TOP_IDX,    8'h00,            1'b1, ERASE_DONE},
        '{FUNC_READ,  21'h000000, 8'h00,            1'b1, ERASE_DONE}
    };

    flash_command_state_machine #(
        .ADDR_BITS   (ADDR_BITS),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Flash model: applies one accepted access, returns the read byte for reads.
    function automatic void flash_access(input logic fw, input logic [20:0] idx,
                                         input logic [7:0] wd, output logic has_rd,
                                         output logic [7:0] rd);
        logic [20:0]  a;
        int unsigned  doomed [$];
        a      = idx & IDX_MASK;
        has_rd = (fw == FUNC_READ);
        rd     = 8'h00;
        if (fw == FUNC_READ)
        begin
            case (fl_mode)
                MODE_IDENT:
                    rd = (a == 21'd0) ? ID_MANUF : (a == 21'd1) ? ID_DEVICE : ID_NONE;
                MODE_STATUS_FIRST:
                begin
                    rd      = ERASE_DONE;
                    fl_mode = MODE_STATUS_LAST;
                end
                MODE_STATUS_LAST:
                begin
                    rd      = ERASE_DONE;
                    fl_mode = MODE_ARRAY;
                end
                // read mode, unlock, program and erase setup all return the stored byte
                default:
                    rd = fl_bytes.exists(a) ? fl_bytes[a] : ERASED;
            endcase
        end
        else
        begin
            case (fl_mode)
                MODE_UNLOCK1:
                    fl_mode = (a == CMD_B_IDX && wd == CMD_UNLOCK_B) ? MODE_UNLOCK2 : MODE_ARRAY;
                MODE_UNLOCK2:
                    if (a != CMD_A_IDX)
                        fl_mode = MODE_ARRAY;
                    else if (wd == CMD_AUTOSEL)
                        fl_mode = MODE_IDENT;
                    else if (wd == CMD_PROGRAM)
                        fl_mode = MODE_BYTE_PGM;
                    else if (wd == CMD_ERASE)
                        fl_mode = MODE_ERASE1;
                    else
                        fl_mode = MODE_ARRAY;
                MODE_ERASE1:
                    fl_mode = (a == CMD_A_IDX && wd == CMD_UNLOCK_A) ? MODE_ERASE2 : MODE_ARRAY;
                MODE_ERASE2:
                    fl_mode = (a == CMD_B_IDX && wd == CMD_UNLOCK_B) ? MODE_ERASE3 : MODE_ARRAY;
                MODE_ERASE3:
                    if (a == CMD_A_IDX && wd == CMD_CHIP_ERASE)
                    begin
                        fl_bytes.delete();
                        fl_mode = MODE_STATUS_FIRST;
                    end
                    else if (wd == CMD_SECTOR_ERASE)
                    begin
                        if (SECTOR_BITS >= ADDR_BITS)
                            fl_bytes.delete();
                        else
                        begin
                            foreach (fl_bytes[k])
                                if ((k >> SECTOR_BITS) == (a >> SECTOR_BITS))
                                    doomed.push_back(k);
                            foreach (doomed[i])
                                fl_bytes.delete(doomed[i]);
                        end
                        fl_mode = MODE_STATUS_FIRST;
                    end
                    else
                        fl_mode = MODE_ARRAY;
                MODE_BYTE_PGM:
                begin
                    fl_bytes[a] = wd;   // plain overwrite
                    fl_mode     = MODE_ARRAY;
                end
                // read mode, autoselect and erase status: 5555:AA starts an unlock, else read mode
                default:
                    fl_mode = (a == CMD_A_IDX && wd == CMD_UNLOCK_A) ? MODE_UNLOCK1 : MODE_ARRAY;
            endcase
        end
    endfunction

    // Index mix: read-back of programmed bytes, low bytes, sector edges, anywhere.
    function automatic logic [20:0] pick_addr();
        logic [20:0] sect;
        sect = 21'($urandom_range(0, (1 << (ADDR_BITS - SECTOR_BITS)) - 1) << SECTOR_BITS);
        case ($urandom_range(0, 5))
            0, 1:
                if (hot_addrs.size() != 0)
                    return hot_addrs[$urandom_range(0, hot_addrs.size() - 1)];
                else
                    return 21'($urandom);
            2:       return 21'($urandom_range(0, 63));
            3:       return sect | ($urandom_range(0, 1) ? 21'((1 << SECTOR_BITS) - 1) : 21'd0);
            default: return 21'($urandom);
        endcase
    endfunction

    // Drive one access after a random gap and hold it until taken; the model is
    // updated at the accepting edge. A known value overrides the model's read byte.
    task automatic issue(input logic fw, input logic [20:0] idx, input logic [7:0] wd,
                         input logic known, input logic [7:0] want);
        int         gap;
        logic       has_rd;
        logic [7:0] rd;
        if ($urandom_range(0, 39) == 0)
            src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // keep the run length bounded: turn surplus erase confirms into plain mismatches
        if (fw == FUNC_WRITE && fl_mode == MODE_ERASE3)
        begin
            if (wd == CMD_CHIP_ERASE && (idx & IDX_MASK) == CMD_A_IDX && !chip_erase_ok)
                wd ^= 8'h01;
            else if (wd == CMD_SECTOR_ERASE && sector_erases_left == 0)
                wd ^= 8'h01;
            else if (wd == CMD_SECTOR_ERASE)
                sector_erases_left--;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fw;
        s_tdata  <= {3'b000, wd, idx};
        do
            @(posedge clk);
        while (!s_tready);
        flash_access(fw, idx, wd, has_rd, rd);
        if (has_rd)
            read_expect.push_back(known ? want : rd);
        n_sent++;
    endtask

    task automatic read_flash(input logic [20:0] idx);
        issue(FUNC_READ, idx, 8'($urandom), 1'b0, 8'h00);
    endtask

    task automatic write_flash(input logic [20:0] idx, input logic [7:0] wd);
        issue(FUNC_WRITE, idx, wd, 1'b0, 8'h00);
    endtask

    // unlock pair, with the odd read slipped in (reads do not disturb the sequence)
    task automatic unlock_pair();
        write_flash(CMD_A_IDX, CMD_UNLOCK_A);
        if ($urandom_range(0, 6) == 0)
            read_flash(pick_addr());
        write_flash(CMD_B_IDX, CMD_UNLOCK_B);
        if ($urandom_range(0, 6) == 0)
            read_flash(pick_addr());
    endtask

    task automatic send_command(input logic [7:0] cmd);
        unlock_pair();
        write_flash(CMD_A_IDX, cmd);
    endtask

    // stimulus
    initial
    begin : stimulus
        int          pick;
        int          cut;
        logic [20:0] step_a;
        logic [7:0]  step_d;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            issue(script[i].fw, script[i].idx, script[i].wd, script[i].known, script[i].want);
        chip_erase_ok = 1'b0;

        while (n_sent < $size(script) + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                read_flash(pick_addr());
            else if (pick < 55)
            begin
                // program, usually read back later through hot_addrs
                send_command(CMD_PROGRAM);
                step_a = pick_addr();
                write_flash(step_a, 8'($urandom));
                hot_addrs.push_back(step_a);
                if (hot_addrs.size() > 64)
                    void'(hot_addrs.pop_front());
                if ($urandom_range(0, 1) == 0)
                    read_flash(step_a);
            end
            else if (pick < 63)
            begin
                send_command(CMD_AUTOSEL);
                repeat ($urandom_range(1, 4))
                    case ($urandom_range(0, 2))
                        0:       read_flash(21'd0);
                        1:       read_flash(21'd1);
                        default: read_flash(pick_addr());
                    endcase
            end
            else if (pick < 67)
            begin
                // sector erase; past the budget it degrades into a failed confirm
                send_command(CMD_ERASE);
                unlock_pair();
                write_flash(pick_addr(), CMD_SECTOR_ERASE);
                if ($urandom_range(0, 3) == 0)
                    write_flash(pick_addr(), 8'($urandom));
                repeat ($urandom_range(2, 4))
                    read_flash(pick_addr());
            end
            else if (pick < 85)
            begin
                // erase path cut short by one bad address or byte
                cut = $urandom_range(0, 4);
                for (int i = 0; i <= cut; i++)
                begin
                    step_a = (i == 1 || i == 4) ? CMD_B_IDX : CMD_A_IDX;
                    case (i)
                        0, 3:    step_d = CMD_UNLOCK_A;
                        1, 4:    step_d = CMD_UNLOCK_B;
                        default: step_d = CMD_ERASE;
                    endcase
                    if (i == cut)
                        case ($urandom_range(0, 2))
                            0:       step_a = 21'($urandom);
                            1:       step_d = 8'($urandom);
                            default: step_a = (step_a == CMD_A_IDX) ? CMD_B_IDX : CMD_A_IDX;
                        endcase
                    write_flash(step_a, step_d);
                end
                read_flash(pick_addr());
            end
            else
            begin
                // noise, leaning on command addresses and command bytes
                case ($urandom_range(0, 3))
                    0:       step_a = CMD_A_IDX;
                    1:       step_a = CMD_B_IDX;
                    default: step_a = pick_addr();
                endcase
                case ($urandom_range(0, 17))
                    0:       step_d = CMD_UNLOCK_A;
                    1:       step_d = CMD_UNLOCK_B;
                    2:       step_d = CMD_AUTOSEL;
                    3:       step_d = CMD_PROGRAM;
                    4:       step_d = CMD_ERASE;
                    5:       step_d = CMD_CHIP_ERASE;
                    6:       step_d = CMD_SECTOR_ERASE;
                    default: step_d = 8'($urandom);
                endcase
                issue(1'($urandom_range(0, 1)), step_a, step_d, 1'b0, 8'h00);
            end
        end
        s_tvalid <= 1'b0;

        while (read_expect.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // read results: random back-pressure, each item checked against the oldest expectation
    initial
    begin : result_sink
        int         stall;
        logic [7:0] want;
        @(posedge clk iff rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                snk_burst = !snk_burst;
            stall = snk_burst ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            if (read_expect.size() == 0)
            begin
                $error("read_data: no read pending, got %02h", m_tdata);
                errors++;
            end
            else
            begin
                want = read_expect.pop_front();
                if (m_tdata !== want)
                begin
                    $error("read_data: expected %02h, got %02h", want, m_tdata);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
